[rtl/core/gtr_pkg.sv]
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types, sizes and command codes of the glyph text renderer.
// ----------------------------------------------------------------------------
package gtr_pkg;

    localparam int GLYPH_ROWS = 16;
    localparam int FONT_BYTES = 4096;   // power of two

    localparam int ADDR_W   = 24;
    localparam int COORD_W  = 12;
    localparam int COLOR_W  = 8;
    localparam int CODE_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam int FONT_AW = $clog2(FONT_BYTES);
    localparam int ROW_W   = $clog2(GLYPH_ROWS);
    localparam int GIDX_W  = (FONT_AW > CODE_W + ROW_W) ? FONT_AW : CODE_W + ROW_W + 1;

    localparam logic [COORD_W-1:0] CHAR_ADVANCE = COORD_W'(8);
    localparam logic [COORD_W-1:0] STRIDE_RESET = COORD_W'(320);

    localparam logic [CMD_W-1:0] CMD_FONT_WR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW_POS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW_CUR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE = 1'd1;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [COORD_W-1:0] stride;
    } t_cfg;

    typedef struct packed {
        logic               go;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic [CODE_W-1:0]  code;
    } t_draw_req;

    typedef struct packed {
        logic               we;
        logic [FONT_AW-1:0] addr;
        logic [BYTE_W-1:0]  data;
    } t_font_wr;

endpackage

[rtl/core/gtr_ram.sv]
// ----------------------------------------------------------------------------
// gtr_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module gtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/gtr_glyph_seq.sv]
// ----------------------------------------------------------------------------
// gtr_glyph_seq
// Font store and row sequencer: reads one glyph row per cycle and emits
// one masked row write per row.
// ----------------------------------------------------------------------------
module gtr_glyph_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gtr_pkg::t_cfg              i_cfg,
    input  gtr_pkg::t_draw_req         i_draw,
    input  gtr_pkg::t_font_wr          i_font_wr,
    output logic                       o_busy,
    output logic                       o_strobe,
    output logic [gtr_pkg::ADDR_W-1:0]  o_pixel_addr,
    output logic [gtr_pkg::BYTE_W-1:0]  o_pixel_mask,
    output logic [gtr_pkg::COLOR_W-1:0] o_pixel_color,
    output logic                       o_last_row
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_ROWS = 2'd2;

    localparam logic [gtr_pkg::ROW_W-1:0] LAST_ROW = gtr_pkg::ROW_W'(gtr_pkg::GLYPH_ROWS - 1);

    logic [1:0]                       r_state, n_state;
    logic [gtr_pkg::ROW_W-1:0]        r_row, n_row;
    logic [gtr_pkg::COORD_W-1:0]      r_x;
    logic [gtr_pkg::COLOR_W-1:0]      r_color;
    logic [gtr_pkg::CODE_W-1:0]       r_code;
    logic [2*gtr_pkg::COORD_W-1:0]    r_prod;
    logic [gtr_pkg::ADDR_W-1:0]       r_addr, n_addr;

    logic [gtr_pkg::ROW_W:0]          rd_row;
    logic [gtr_pkg::GIDX_W-1:0]       gidx;
    logic                             rd_en;
    logic [gtr_pkg::FONT_AW-1:0]      ram_addr;
    logic [gtr_pkg::ADDR_W+1:0]       first_addr;
    logic                             is_last;

    assign is_last = (r_row == LAST_ROW);
    assign rd_row  = (r_state == ST_ADDR) ? '0 : ({1'b0, r_row} + 1'b1);
    assign gidx    = gtr_pkg::GIDX_W'(r_code) * gtr_pkg::GIDX_W'(gtr_pkg::GLYPH_ROWS)
                   + gtr_pkg::GIDX_W'(rd_row);
    assign rd_en   = (r_state == ST_ADDR) || ((r_state == ST_ROWS) && !is_last);
    assign ram_addr = i_font_wr.we ? i_font_wr.addr : gidx[gtr_pkg::FONT_AW-1:0];

    assign first_addr = (gtr_pkg::ADDR_W+2)'(i_cfg.base) + (gtr_pkg::ADDR_W+2)'(r_prod)
                      + (gtr_pkg::ADDR_W+2)'(r_x);

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_addr  = r_addr;
        unique case (r_state)
            ST_IDLE: begin
                if (i_draw.go) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_state = ST_ROWS;
                n_row   = '0;
                n_addr  = first_addr[gtr_pkg::ADDR_W-1:0];
            end
            ST_ROWS: begin
                n_row  = r_row + 1'b1;
                n_addr = r_addr + gtr_pkg::ADDR_W'(i_cfg.stride);
                if (is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (i_draw.go) begin
            r_x     <= i_draw.x;
            r_color <= i_draw.color;
            r_code  <= i_draw.code;
            r_prod  <= (2*gtr_pkg::COORD_W)'(i_draw.y) * (2*gtr_pkg::COORD_W)'(i_cfg.stride);
        end
    end

    gtr_ram #(
        .WIDTH (gtr_pkg::BYTE_W),
        .DEPTH (gtr_pkg::FONT_BYTES)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (i_font_wr.we),
        .i_re    (rd_en),
        .i_addr  (ram_addr),
        .i_wdata (i_font_wr.data),
        .o_rdata (o_pixel_mask)
    );

    assign o_busy        = (r_state != ST_IDLE);
    assign o_strobe      = (r_state == ST_ROWS);
    assign o_pixel_addr  = r_addr;
    assign o_pixel_color = r_color;
    assign o_last_row    = o_strobe && is_last;

    a_draw_enters_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_draw.go && r_state == ST_IDLE) |=> (r_state == ST_ADDR))
        else $error("draw start did not enter address setup");

    a_last_ends_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROWS && is_last) |=> (r_state == ST_IDLE))
        else $error("draw did not end after last row");

    a_no_font_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_font_wr.we |-> (r_state == ST_IDLE && !i_draw.go))
        else $error("font write during a draw");

    a_row_zero_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADDR) |=> (r_state == ST_ROWS && r_row == '0))
        else $error("row walk did not start at row zero");

endmodule

[rtl/core/glyph_text_renderer_core.sv]
// ----------------------------------------------------------------------------
// glyph_text_renderer_core
// 8x16 bitmap font character generator: font store load, cursor handling
// and one masked framebuffer row write per glyph row.
//
//  channel  | ports                                       | handshake
//  ---------+---------------------------------------------+--------------------
//  command  | i_cmd i_font_index i_font_byte i_x_pos      | start & !busy
//           | i_y_pos i_ink i_char_code                   |
//  result   | o_pixel_addr o_pixel_mask o_pixel_color     | o_strobe, 1 cycle
//           | o_last_row                                  |
//  config   | i_cfg_idx i_cfg_data                        | i_cfg_we
//
// Font write: busy stays low. Draw: busy through an address setup state
// and the glyph row states; the next word is taken once busy falls. One
// font store read per glyph row sets the pace.
// Results come back to back, one per cycle, 16 per draw.
// Reset is synchronous; the font store is not cleared.
// The receiver cannot stall: results are never held.
// ----------------------------------------------------------------------------
module glyph_text_renderer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [gtr_pkg::CMD_W-1:0]      i_cmd,
    input  logic [gtr_pkg::FONT_AW-1:0]    i_font_index,
    input  logic [gtr_pkg::BYTE_W-1:0]     i_font_byte,
    input  logic [gtr_pkg::COORD_W-1:0]    i_x_pos,
    input  logic [gtr_pkg::COORD_W-1:0]    i_y_pos,
    input  logic [gtr_pkg::COLOR_W-1:0]    i_ink,
    input  logic [gtr_pkg::CODE_W-1:0]     i_char_code,
    input  logic                          i_cfg_we,
    input  logic [gtr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gtr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_strobe,
    output logic [gtr_pkg::ADDR_W-1:0]     o_pixel_addr,
    output logic [gtr_pkg::BYTE_W-1:0]     o_pixel_mask,
    output logic [gtr_pkg::COLOR_W-1:0]    o_pixel_color,
    output logic                          o_last_row
);

    gtr_pkg::t_cfg      r_cfg;
    logic [gtr_pkg::COORD_W-1:0] r_cur_x;
    logic [gtr_pkg::COORD_W-1:0] r_cur_y;
    logic [gtr_pkg::COLOR_W-1:0] r_cur_color;

    gtr_pkg::t_draw_req draw;
    gtr_pkg::t_font_wr  font_wr;
    logic               accept;
    logic               draw_pos;
    logic               draw_cur;

    assign accept   = start && !busy;
    assign draw_pos = accept && (i_cmd == gtr_pkg::CMD_DRAW_POS);
    assign draw_cur = accept && (i_cmd == gtr_pkg::CMD_DRAW_CUR);

    assign draw.go    = draw_pos || draw_cur;
    assign draw.x     = draw_pos ? i_x_pos : r_cur_x;
    assign draw.y     = draw_pos ? i_y_pos : r_cur_y;
    assign draw.color = draw_pos ? i_ink   : r_cur_color;
    assign draw.code  = i_char_code;

    assign font_wr.we   = accept && (i_cmd == gtr_pkg::CMD_FONT_WR);
    assign font_wr.addr = i_font_index;
    assign font_wr.data = i_font_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base   <= '0;
            r_cfg.stride <= gtr_pkg::STRIDE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gtr_pkg::REG_FRAME_BASE: r_cfg.base   <= i_cfg_data[gtr_pkg::ADDR_W-1:0];
                gtr_pkg::REG_ROW_STRIDE: r_cfg.stride <= i_cfg_data[gtr_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_cur_color <= '0;
        end else if (draw.go) begin
            r_cur_x     <= draw.x + gtr_pkg::CHAR_ADVANCE;
            r_cur_y     <= draw.y;
            r_cur_color <= draw.color;
        end
    end

    gtr_glyph_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_draw        (draw),
        .i_font_wr     (font_wr),
        .o_busy        (busy),
        .o_strobe      (o_strobe),
        .o_pixel_addr  (o_pixel_addr),
        .o_pixel_mask  (o_pixel_mask),
        .o_pixel_color (o_pixel_color),
        .o_last_row    (o_last_row)
    );

endmodule
